/* sv/lspd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and reset values for the LED status pattern driver.
// No dependencies; the files that use it refer to it by scoped names.
package lspd_pkg;

  localparam int unsigned MAX_LEDS_DEF = 64;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned ENTRY_W = MODE_W + COLOR_W;
  localparam int unsigned WAIT_W  = 16;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned CFG_IDX_W = 3;

  // opcodes
  localparam logic [1:0] OP_SET     = 2'd0;
  localparam logic [1:0] OP_SET_ALL = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_QUERY   = 2'd3;

  // LED modes; codes above MODE_FLICKER are stored but shown dark
  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_ON      = 3'd1;
  localparam logic [2:0] MODE_BLINK   = 3'd2;
  localparam logic [2:0] MODE_FLASH   = 3'd3;
  localparam logic [2:0] MODE_FLICKER = 3'd4;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_LED_COUNT        = 3'd0;
  localparam logic [2:0] REG_BLINK_ON_WAIT    = 3'd1;
  localparam logic [2:0] REG_BLINK_OFF_WAIT   = 3'd2;
  localparam logic [2:0] REG_FLASH_ON_WAIT    = 3'd3;
  localparam logic [2:0] REG_FLASH_OFF_WAIT   = 3'd4;
  localparam logic [2:0] REG_FLICKER_ON_WAIT  = 3'd5;
  localparam logic [2:0] REG_FLICKER_OFF_WAIT = 3'd6;

  localparam logic [6:0]  LED_COUNT_RST        = 7'd64;
  localparam logic [15:0] BLINK_ON_WAIT_RST    = 16'd1000;
  localparam logic [15:0] BLINK_OFF_WAIT_RST   = 16'd1000;
  localparam logic [15:0] FLASH_ON_WAIT_RST    = 16'd1000;
  localparam logic [15:0] FLASH_OFF_WAIT_RST   = 16'd100;
  localparam logic [15:0] FLICKER_ON_WAIT_RST  = 16'd50;
  localparam logic [15:0] FLICKER_OFF_WAIT_RST = 16'd50;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  led_index;
    logic [2:0]  led_mode;
    logic [23:0] led_color;
  } lspd_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [5:0]  pixel_index;
    logic [23:0] pixel_color;
    logic [2:0]  mode_read;
    logic        last_item;
  } lspd_out_t;

  // whether an LED in the given mode is lit under the current phases
  function automatic logic pixel_lit(input logic [2:0] mode, input logic blink,
                                     input logic flash, input logic flicker);
    logic lit;
    case (mode)
      MODE_ON:      lit = 1'b1;
      MODE_BLINK:   lit = blink;
      MODE_FLASH:   lit = flash;
      MODE_FLICKER: lit = flicker;
      default:      lit = 1'b0;
    endcase
    return lit;
  endfunction

endpackage

/* sv/led_status_pattern_driver.sv */
`timescale 1ns / 1ps
// LED status pattern driver: LED table sequencer, config registers, output stage.
// Depends on lspd_pkg, lspd_ram, lspd_phase_gen.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+------------------------------
//  command | start, busy, item_i                       | taken when start && !busy
//  result  | result_valid_o, result_o                  | one-cycle strobe, no stall
//  config  | cfg_valid_i, cfg_ready_o, cfg_index_i,    | written when valid && ready
//          | cfg_data_i                                |
//
// A set, set-all or tick walks the LEDs in use one entry per cycle, so busy stays
// high until the last entry leaves the read stage; pixels pass the result register,
// set and tick via the single RAM read port. A query holds busy during its read stage.
// After reset every table entry reads as off/zero through per-entry valid flops;
// no clearing pass is needed. Results cannot be stalled by the receiver.
// cfg_ready_o is low while a command is offered or in flight.
module led_status_pattern_driver #(
  parameter int unsigned MAX_LEDS = lspd_pkg::MAX_LEDS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  lspd_pkg::lspd_in_t             item_i,
  output logic                           result_valid_o,
  output lspd_pkg::lspd_out_t            result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lspd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lspd_pkg::WAIT_W-1:0]    cfg_data_i
);

  localparam int unsigned AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_FILL = 3'b100
  } state_e;

  // config registers
  logic [lspd_pkg::COUNT_W-1:0] led_count_q;
  logic [lspd_pkg::WAIT_W-1:0]  blink_on_q, blink_off_q, flash_on_q, flash_off_q;
  logic [lspd_pkg::WAIT_W-1:0]  flicker_on_q, flicker_off_q;

  // registers change only between commands
  assign cfg_ready_o = !busy && !start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q   <= lspd_pkg::LED_COUNT_RST;
      blink_on_q    <= lspd_pkg::BLINK_ON_WAIT_RST;
      blink_off_q   <= lspd_pkg::BLINK_OFF_WAIT_RST;
      flash_on_q    <= lspd_pkg::FLASH_ON_WAIT_RST;
      flash_off_q   <= lspd_pkg::FLASH_OFF_WAIT_RST;
      flicker_on_q  <= lspd_pkg::FLICKER_ON_WAIT_RST;
      flicker_off_q <= lspd_pkg::FLICKER_OFF_WAIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        lspd_pkg::REG_LED_COUNT:        led_count_q   <= cfg_data_i[lspd_pkg::COUNT_W-1:0];
        lspd_pkg::REG_BLINK_ON_WAIT:    blink_on_q    <= cfg_data_i;
        lspd_pkg::REG_BLINK_OFF_WAIT:   blink_off_q   <= cfg_data_i;
        lspd_pkg::REG_FLASH_ON_WAIT:    flash_on_q    <= cfg_data_i;
        lspd_pkg::REG_FLASH_OFF_WAIT:   flash_off_q   <= cfg_data_i;
        lspd_pkg::REG_FLICKER_ON_WAIT:  flicker_on_q  <= cfg_data_i;
        lspd_pkg::REG_FLICKER_OFF_WAIT: flicker_off_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // LEDs in use, clamped to the table size
  logic [lspd_pkg::COUNT_W-1:0] cnt_n;
  assign cnt_n = (led_count_q > lspd_pkg::COUNT_W'(MAX_LEDS)) ?
                 lspd_pkg::COUNT_W'(MAX_LEDS) : led_count_q;

  logic accept, tick, idx_in;
  assign accept = start && !busy;
  assign tick   = accept && (item_i.opcode == lspd_pkg::OP_TICK);
  assign idx_in = {1'b0, item_i.led_index} < {2'b00, cnt_n};

  logic blink_ph, flash_ph, flicker_ph;

  lspd_phase_gen u_blink (
    .clk_i, .rst_ni, .tick_i(tick), .on_wait_i(blink_on_q), .off_wait_i(blink_off_q),
    .phase_o(blink_ph)
  );
  lspd_phase_gen u_flash (
    .clk_i, .rst_ni, .tick_i(tick), .on_wait_i(flash_on_q), .off_wait_i(flash_off_q),
    .phase_o(flash_ph)
  );
  lspd_phase_gen u_flicker (
    .clk_i, .rst_ni, .tick_i(tick), .on_wait_i(flicker_on_q),
    .off_wait_i(flicker_off_q), .phase_o(flicker_ph)
  );

  // sequencer
  state_e                       state_q, state_d;
  logic [AW-1:0]                ptr_q, ptr_d;
  lspd_pkg::lspd_in_t           item_q, item_d;
  logic                         ptr_last;

  logic                         ram_we, ram_re;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  logic [lspd_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [MAX_LEDS-1:0]          vld_q;

  // read stage
  logic       rd_vld_q, rd_vld_d;
  logic       rd_fwd_q, rd_fwd_d;
  logic       rd_kind_q, rd_kind_d;
  logic       rd_last_q, rd_last_d;
  logic       rd_inr_q, rd_inr_d;
  logic       rd_vbit_q, rd_vbit_d;
  logic [5:0] rd_pix_q, rd_pix_d;

  assign ptr_last = (lspd_pkg::COUNT_W'(ptr_q) + 1'b1) == cnt_n;

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    item_d    = item_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = {item_q.led_mode, item_q.led_color};
    ram_re    = 1'b0;
    ram_raddr = ptr_q;
    rd_vld_d  = 1'b0;
    rd_fwd_d  = 1'b0;
    rd_kind_d = lspd_pkg::KIND_PIXEL;
    rd_last_d = ptr_last;
    rd_inr_d  = 1'b1;
    rd_pix_d  = 6'(ptr_q);
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d = item_i;
          ptr_d  = '0;
          unique case (item_i.opcode)
            lspd_pkg::OP_SET: begin
              if (idx_in) begin
                ram_we    = 1'b1;
                ram_waddr = item_i.led_index[AW-1:0];
                ram_wdata = {item_i.led_mode, item_i.led_color};
                state_d   = S_READ;
              end
            end
            lspd_pkg::OP_SET_ALL: begin
              if (cnt_n != '0) state_d = S_FILL;
            end
            lspd_pkg::OP_TICK: begin
              if (cnt_n != '0) state_d = S_READ;
            end
            lspd_pkg::OP_QUERY: begin
              ram_re    = 1'b1;
              ram_raddr = item_i.led_index[AW-1:0];
              rd_vld_d  = 1'b1;
              rd_kind_d = lspd_pkg::KIND_QUERY;
              rd_last_d = 1'b1;
              rd_inr_d  = idx_in;
              rd_pix_d  = item_i.led_index[5:0];
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        ram_re   = 1'b1;
        rd_vld_d = 1'b1;
        if (ptr_last) state_d = S_IDLE;
        else          ptr_d   = ptr_q + AW'(1);
      end
      S_FILL: begin
        // entry is written and its pixel forwarded from the latched word
        ram_we   = 1'b1;
        rd_vld_d = 1'b1;
        rd_fwd_d = 1'b1;
        if (ptr_last) state_d = S_IDLE;
        else          ptr_d   = ptr_q + AW'(1);
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign rd_vbit_d = ram_re && rd_inr_d && vld_q[ram_raddr];
  assign busy      = (state_q != S_IDLE) || rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ptr_q    <= '0;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      rd_vld_q <= rd_vld_d;
      if (ram_we) vld_q[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    rd_fwd_q  <= rd_fwd_d;
    rd_kind_q <= rd_kind_d;
    rd_last_q <= rd_last_d;
    rd_inr_q  <= rd_inr_d;
    rd_vbit_q <= rd_vbit_d;
    rd_pix_q  <= rd_pix_d;
  end

  lspd_ram #(
    .WIDTH(lspd_pkg::ENTRY_W),
    .DEPTH(MAX_LEDS)
  ) u_table (
    .clk_i,
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // output stage
  logic [lspd_pkg::ENTRY_W-1:0] entry;
  logic [2:0]                   ent_mode;
  logic [23:0]                  ent_color;
  lspd_pkg::lspd_out_t          res_d, result_q;
  logic                         result_valid_q;

  always_comb begin
    if (rd_fwd_q)       entry = {item_q.led_mode, item_q.led_color};
    else if (rd_vbit_q) entry = ram_rdata;
    else                entry = '0;
    ent_mode  = entry[lspd_pkg::ENTRY_W-1 -: lspd_pkg::MODE_W];
    ent_color = entry[lspd_pkg::COLOR_W-1:0];

    res_d.result_kind = rd_kind_q;
    res_d.pixel_index = rd_pix_q;
    res_d.last_item   = rd_last_q;
    if (rd_kind_q == lspd_pkg::KIND_QUERY) begin
      res_d.pixel_color = rd_inr_q ? ent_color : '0;
      res_d.mode_read   = rd_inr_q ? ent_mode : lspd_pkg::MODE_OFF;
    end else begin
      res_d.pixel_color = lspd_pkg::pixel_lit(ent_mode, blink_ph, flash_ph, flicker_ph) ?
                          ent_color : '0;
      res_d.mode_read   = lspd_pkg::MODE_OFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) result_valid_q <= 1'b0;
    else         result_valid_q <= rd_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) result_q <= res_d;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // assertions
  a_read_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |=> result_valid_o)
    else $error("read stage word did not reach the result port");

  a_last_pixel_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.result_kind == lspd_pkg::KIND_PIXEL && result_o.last_item)
      |-> (result_o.pixel_index == 6'(cnt_n - 1'b1)))
    else $error("frame ended at the wrong LED");

  a_query_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.opcode == lspd_pkg::OP_QUERY)
      |=> ##1 (result_valid_o && result_o.result_kind == lspd_pkg::KIND_QUERY))
    else $error("query answer missing two cycles after accept");

endmodule

/* sv/lspd_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lspd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/lspd_phase_gen.sv */
`timescale 1ns / 1ps
// One on/off phase generator driven by millisecond ticks, saturating count.
// Depends on lspd_pkg.
module lspd_phase_gen (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        tick_i,
  input  logic [lspd_pkg::WAIT_W-1:0] on_wait_i,
  input  logic [lspd_pkg::WAIT_W-1:0] off_wait_i,
  output logic                        phase_o
);

  logic                        phase_q, phase_d;
  logic [lspd_pkg::WAIT_W-1:0] elapsed_q, elapsed_d;
  logic [lspd_pkg::WAIT_W-1:0] elapsed_inc;

  always_comb begin
    elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
    phase_d     = phase_q;
    elapsed_d   = elapsed_q;
    if (tick_i) begin
      elapsed_d = elapsed_inc;
      if (!phase_q && elapsed_inc >= on_wait_i) begin
        phase_d   = 1'b1;
        elapsed_d = '0;
      end else if (phase_q && elapsed_inc >= off_wait_i) begin
        phase_d   = 1'b0;
        elapsed_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= 1'b0;
      elapsed_q <= '0;
    end else begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign phase_o = phase_q;

endmodule
